// ===== src/ffhp_pkg.sv =====
`default_nettype none
package ffhp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NUMBER_W = 36;
    localparam int unsigned SAMP_W   = 16;
    localparam int unsigned RATE_W   = 18;
    localparam int unsigned CHAN_W   = 5;
    localparam int unsigned BITS_W   = 5;
    localparam int unsigned CONT_W   = 3;

    localparam logic [BYTE_W-1:0] SYNC0_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC1_MASK = 8'hFC;
    localparam logic [BYTE_W-1:0] SYNC1_CODE = 8'hF8;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SYNC = 2'd1,
        ST_LEAD = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        POS_SYNC0 = 3'd0,
        POS_SYNC1 = 3'd1,
        POS_SIZE  = 3'd2,
        POS_CHAN  = 3'd3,
        POS_LEAD  = 3'd4,
        POS_CONT  = 3'd5
    } t_pos;

    typedef struct packed {
        t_status               status;
        logic                  variable_blocking;
        logic [SAMP_W-1:0]     block_samples;
        logic [RATE_W-1:0]     rate_hz;
        logic [CHAN_W-1:0]     channel_count;
        logic [BITS_W-1:0]     sample_bits;
        logic [NUMBER_W-1:0]   coded_number;
    } t_result;

    function automatic logic [SAMP_W-1:0] f_samples(input logic [3:0] code);
        logic [SAMP_W-1:0] v;
        case (code)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd192;
            4'd2:    v = 16'd576;
            4'd3:    v = 16'd1152;
            4'd4:    v = 16'd2304;
            4'd5:    v = 16'd4608;
            4'd6:    v = 16'd1;
            4'd7:    v = 16'd2;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd512;
            4'd10:   v = 16'd1024;
            4'd11:   v = 16'd2048;
            4'd12:   v = 16'd4096;
            4'd13:   v = 16'd8192;
            4'd14:   v = 16'd16384;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

    function automatic logic [RATE_W-1:0] f_rate(input logic [3:0] code);
        logic [RATE_W-1:0] v;
        case (code)
            4'd1:    v = 18'd88200;
            4'd2:    v = 18'd176400;
            4'd3:    v = 18'd192000;
            4'd4:    v = 18'd8000;
            4'd5:    v = 18'd16000;
            4'd6:    v = 18'd22050;
            4'd7:    v = 18'd24000;
            4'd8:    v = 18'd32000;
            4'd9:    v = 18'd44100;
            4'd10:   v = 18'd48000;
            4'd11:   v = 18'd96000;
            4'd12:   v = 18'd1;
            4'd13:   v = 18'd2;
            4'd14:   v = 18'd3;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

    function automatic logic [BITS_W-1:0] f_bits(input logic [2:0] code);
        logic [BITS_W-1:0] v;
        case (code)
            3'd1:    v = 5'd8;
            3'd2:    v = 5'd12;
            3'd4:    v = 5'd16;
            3'd5:    v = 5'd20;
            3'd6:    v = 5'd24;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== src/ffhp_decode.sv =====
`default_nettype none
module ffhp_decode (
    input  wire logic                           i_sync_err,
    input  wire ffhp_pkg::t_status              i_status,
    input  wire logic                           i_blocking,
    input  wire logic [ffhp_pkg::BYTE_W-1:0]    i_size_rate,
    input  wire logic [ffhp_pkg::BYTE_W-1:0]    i_chan_bits,
    input  wire logic [ffhp_pkg::NUMBER_W-1:0]  i_number,
    output ffhp_pkg::t_result                   o_result
);
    import ffhp_pkg::*;

    logic [CHAN_W-1:0] chan;

    always_comb begin
        case (i_chan_bits[7:4])
            4'd8, 4'd9, 4'd10: chan = 5'd2;
            default:           chan = {1'b0, i_chan_bits[7:4]} + 5'd1;
        endcase
    end

    always_comb begin
        if (i_sync_err) begin
            o_result        = '0;
            o_result.status = ST_SYNC;
        end else begin
            o_result.status            = i_status;
            o_result.variable_blocking = i_blocking;
            o_result.block_samples     = f_samples(i_size_rate[7:4]);
            o_result.rate_hz           = f_rate(i_size_rate[3:0]);
            o_result.channel_count     = chan;
            o_result.sample_bits       = f_bits(i_chan_bits[3:1]);
            o_result.coded_number      = i_number;
        end
    end

endmodule
`default_nettype wire

// ===== src/ffhp_parser.sv =====
`default_nettype none
module ffhp_parser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [ffhp_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                         i_start,
    output logic                              o_emit,
    output ffhp_pkg::t_result                 o_result
);
    import ffhp_pkg::*;

    logic                r_active, n_active;
    t_pos                r_pos, n_pos;
    logic [CONT_W-1:0]   r_cont, n_cont;
    logic [NUMBER_W-1:0] r_acc, n_acc;
    logic                r_blocking, n_blocking;
    logic [BYTE_W-1:0]   r_size_rate, n_size_rate;
    logic [BYTE_W-1:0]   r_chan_bits, n_chan_bits;

    logic                active;
    t_pos                pos;
    logic [CONT_W-1:0]   cont;
    logic [NUMBER_W-1:0] acc;
    logic                lead_ok;
    logic [CONT_W-1:0]   lead_extra;
    logic [6:0]          lead_val;
    logic [CONT_W-1:0]   cont_dec;
    logic                sync_err;
    t_status             status;
    logic [NUMBER_W-1:0] number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pos       <= POS_SYNC0;
            r_cont      <= '0;
            r_acc       <= '0;
            r_blocking  <= 1'b0;
            r_size_rate <= '0;
            r_chan_bits <= '0;
        end else if (i_en) begin
            r_active    <= n_active;
            r_pos       <= n_pos;
            r_cont      <= n_cont;
            r_acc       <= n_acc;
            r_blocking  <= n_blocking;
            r_size_rate <= n_size_rate;
            r_chan_bits <= n_chan_bits;
        end
    end

    // lead byte of the coded number: length and value bits
    always_comb begin
        lead_ok    = 1'b1;
        lead_extra = 3'd0;
        lead_val   = 7'd0;
        if (i_byte[7] == 1'b0) begin
            lead_val = i_byte[6:0];
        end else if (i_byte[7:5] == 3'b110) begin
            lead_extra = 3'd1;
            lead_val   = {2'b0, i_byte[4:0]};
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_extra = 3'd2;
            lead_val   = {3'b0, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_extra = 3'd3;
            lead_val   = {4'b0, i_byte[2:0]};
        end else if (i_byte[7:2] == 6'b111110) begin
            lead_extra = 3'd4;
            lead_val   = {5'b0, i_byte[1:0]};
        end else if (i_byte[7:1] == 7'b1111110) begin
            lead_extra = 3'd5;
            lead_val   = {6'b0, i_byte[0]};
        end else if (i_byte == 8'hFE) begin
            lead_extra = 3'd6;
        end else begin
            lead_ok = 1'b0;
        end
    end

    always_comb begin
        active = i_start ? 1'b1 : r_active;
        pos    = i_start ? POS_SYNC0 : r_pos;
        cont   = i_start ? '0 : r_cont;
        acc    = i_start ? '0 : r_acc;

        n_active    = active;
        n_pos       = pos;
        n_cont      = cont;
        n_acc       = acc;
        n_blocking  = r_blocking;
        n_size_rate = r_size_rate;
        n_chan_bits = r_chan_bits;

        cont_dec = (cont != '0) ? cont - 3'd1 : cont;
        o_emit   = 1'b0;
        sync_err = 1'b0;
        status   = ST_OK;
        number   = acc;

        if (active) begin
            case (pos)
                POS_SYNC0: begin
                    if (i_byte != SYNC0_BYTE) begin
                        n_active = 1'b0;
                        o_emit   = 1'b1;
                        sync_err = 1'b1;
                    end else begin
                        n_pos = POS_SYNC1;
                    end
                end
                POS_SYNC1: begin
                    if ((i_byte & SYNC1_MASK) != SYNC1_CODE) begin
                        n_active = 1'b0;
                        o_emit   = 1'b1;
                        sync_err = 1'b1;
                    end else begin
                        n_blocking = i_byte[0];
                        n_pos      = POS_SIZE;
                    end
                end
                POS_SIZE: begin
                    n_size_rate = i_byte;
                    n_pos       = POS_CHAN;
                end
                POS_CHAN: begin
                    n_chan_bits = i_byte;
                    n_pos       = POS_LEAD;
                end
                POS_LEAD: begin
                    if (!lead_ok) begin
                        n_active = 1'b0;
                        o_emit   = 1'b1;
                        status   = ST_LEAD;
                        number   = '0;
                    end else begin
                        n_acc  = {{(NUMBER_W-7){1'b0}}, lead_val};
                        number = n_acc;
                        if (lead_extra == '0) begin
                            n_active = 1'b0;
                            o_emit   = 1'b1;
                        end else begin
                            n_cont = lead_extra;
                            n_pos  = POS_CONT;
                        end
                    end
                end
                default: begin
                    n_acc  = {acc[NUMBER_W-7:0], i_byte[5:0]};
                    n_cont = cont_dec;
                    number = n_acc;
                    if (cont_dec == '0) begin
                        n_active = 1'b0;
                        o_emit   = 1'b1;
                    end
                end
            endcase
        end
    end

    ffhp_decode u_decode (
        .i_sync_err  (sync_err),
        .i_status    (status),
        .i_blocking  (r_blocking),
        .i_size_rate (r_size_rate),
        .i_chan_bits (r_chan_bits),
        .i_number    (number),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

// ===== src/flac_frame_header_parser_unit.sv =====
`default_nettype none
// Frame header parser: takes one header byte per cycle on the input channel
// and gives at most one result word per header. The byte that completes the
// header (sync failure, the last byte of the coded number, or an invalid lead
// byte) passes through the input register, and its word is registered in the
// result register once that register is free. Throughput is one byte per
// clock, set by the single input register / parse / result register path;
// back-pressure on the result side stalls the input only when both registers
// are full. Asserting i_frame_start with a byte restarts parsing with that
// byte as the first sync byte; bytes outside a header are dropped.
module flac_frame_header_parser_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [ffhp_pkg::BYTE_W-1:0]    i_header_byte,
    input  wire logic                           i_frame_start,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [1:0]                          o_status,
    output logic                                o_variable_blocking,
    output logic [ffhp_pkg::SAMP_W-1:0]         o_block_samples,
    output logic [ffhp_pkg::RATE_W-1:0]         o_rate_hz,
    output logic [ffhp_pkg::CHAN_W-1:0]         o_channel_count,
    output logic [ffhp_pkg::BITS_W-1:0]         o_sample_bits,
    output logic [ffhp_pkg::NUMBER_W-1:0]       o_coded_number
);
    import ffhp_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic              r_out_valid;
    t_result           r_out;
    logic              advance;
    logic              emit;
    t_result           result;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte  <= i_header_byte;
            r_in_start <= i_frame_start;
        end
    end

    ffhp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_in_valid && advance),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && emit) begin
            r_out <= result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_out.status;
    assign o_variable_blocking = r_out.variable_blocking;
    assign o_block_samples     = r_out.block_samples;
    assign o_rate_hz           = r_out.rate_hz;
    assign o_channel_count     = r_out.channel_count;
    assign o_sample_bits       = r_out.sample_bits;
    assign o_coded_number      = r_out.coded_number;

endmodule
`default_nettype wire

// ===== verif/ffhp_header_monitor.sv =====
`timescale 1ns / 1ps
module ffhp_header_monitor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic [ffhp_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic                          i_start,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [1:0]                    i_status,
    input  wire logic                          i_variable_blocking,
    input  wire logic [ffhp_pkg::SAMP_W-1:0]   i_block_samples,
    input  wire logic [ffhp_pkg::RATE_W-1:0]   i_rate_hz,
    input  wire logic [ffhp_pkg::CHAN_W-1:0]   i_channel_count,
    input  wire logic [ffhp_pkg::BITS_W-1:0]   i_sample_bits,
    input  wire logic [ffhp_pkg::NUMBER_W-1:0] i_coded_number,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_words
);
    import ffhp_pkg::*;

    t_pos                pos;
    logic                active;
    logic                blk_bit;
    logic [BYTE_W-1:0]   size_rate;
    logic [BYTE_W-1:0]   chan_bits;
    logic [NUMBER_W-1:0] number_acc;
    logic [CONT_W-1:0]   cont_left;
    t_result             header_q[$];
    int                  faults = 0;
    int                  words = 0;

    function automatic logic [SAMP_W-1:0] block_size(input logic [3:0] c);
        logic [SAMP_W-1:0] v;
        if (c == 4'd0) v = '0;
        else if (c == 4'd1) v = 16'd192;
        else if (c <= 4'd5) v = 16'd576 << (c - 4'd2);
        else if (c == 4'd6) v = 16'd1;
        else if (c == 4'd7) v = 16'd2;
        else v = 16'd256 << (c - 4'd8);
        return v;
    endfunction

    function automatic logic [RATE_W-1:0] sample_rate(input logic [3:0] c);
        logic [RATE_W-1:0] v;
        case (c)
            4'd1:    v = 18'd88200;
            4'd2:    v = 18'd176400;
            4'd3:    v = 18'd192000;
            4'd4:    v = 18'd8000;
            4'd5:    v = 18'd16000;
            4'd6:    v = 18'd22050;
            4'd7:    v = 18'd24000;
            4'd8:    v = 18'd32000;
            4'd9:    v = 18'd44100;
            4'd10:   v = 18'd48000;
            4'd11:   v = 18'd96000;
            4'd12:   v = 18'd1;
            4'd13:   v = 18'd2;
            4'd14:   v = 18'd3;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] chan_total(input logic [3:0] c);
        logic [CHAN_W-1:0] n;
        n = {1'b0, c} + 5'd1;
        // stereo decorrelation modes
        if (n >= 5'd9 && n <= 5'd11) n = 5'd2;
        return n;
    endfunction

    function automatic logic [BITS_W-1:0] bit_depth(input logic [2:0] c);
        logic [BITS_W-1:0] v;
        case (c)
            3'd1:    v = 5'd8;
            3'd2:    v = 5'd12;
            3'd4:    v = 5'd16;
            3'd5:    v = 5'd20;
            3'd6:    v = 5'd24;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_result decoded_header(input t_status st,
                                               input logic [NUMBER_W-1:0] num);
        t_result r;
        r.status            = st;
        r.variable_blocking = blk_bit;
        r.block_samples     = block_size(size_rate[7:4]);
        r.rate_hz           = sample_rate(size_rate[3:0]);
        r.channel_count     = chan_total(chan_bits[7:4]);
        r.sample_bits       = bit_depth(chan_bits[3:1]);
        r.coded_number      = num;
        return r;
    endfunction

    function automatic t_result sync_fault();
        t_result r;
        r = '0;
        r.status = ST_SYNC;
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("st=%0d vb=%0d blk=%0d rate=%0d ch=%0d bits=%0d num=%0h",
                         r.status, r.variable_blocking, r.block_samples,
                         r.rate_hz, r.channel_count, r.sample_bits,
                         r.coded_number);
    endfunction

    task automatic flag_fault(input string msg);
        faults++;
        if (faults <= 10) $display("%0t ffhp_header_monitor: %s", $time, msg);
    endtask

    task automatic parse_word(input logic [BYTE_W-1:0] b, input logic s);
        logic [2:0] extra;
        logic [7:0] mask;
        logic       bad_lead;
        if (s) begin
            active     = 1'b1;
            pos        = POS_SYNC0;
            cont_left  = '0;
            number_acc = '0;
        end
        if (active) begin
            case (pos)
                POS_SYNC0: begin
                    if (b != SYNC0_BYTE) begin
                        active = 1'b0;
                        header_q.push_back(sync_fault());
                    end else begin
                        pos = POS_SYNC1;
                    end
                end
                POS_SYNC1: begin
                    if ((b & SYNC1_MASK) != SYNC1_CODE) begin
                        active = 1'b0;
                        header_q.push_back(sync_fault());
                    end else begin
                        blk_bit = b[0];
                        pos     = POS_SIZE;
                    end
                end
                POS_SIZE: begin
                    size_rate = b;
                    pos       = POS_CHAN;
                end
                POS_CHAN: begin
                    chan_bits = b;
                    pos       = POS_LEAD;
                end
                POS_LEAD: begin
                    bad_lead = 1'b0;
                    extra    = '0;
                    mask     = '0;
                    casez (b)
                        8'b0???????: begin extra = 3'd0; mask = 8'h7F; end
                        8'b110?????: begin extra = 3'd1; mask = 8'h1F; end
                        8'b1110????: begin extra = 3'd2; mask = 8'h0F; end
                        8'b11110???: begin extra = 3'd3; mask = 8'h07; end
                        8'b111110??: begin extra = 3'd4; mask = 8'h03; end
                        8'b1111110?: begin extra = 3'd5; mask = 8'h01; end
                        8'b11111110: begin extra = 3'd6; mask = 8'h00; end
                        default:     bad_lead = 1'b1;
                    endcase
                    if (bad_lead) begin
                        active = 1'b0;
                        header_q.push_back(decoded_header(ST_LEAD, '0));
                    end else begin
                        number_acc = {28'd0, b & mask};
                        if (extra == 3'd0) begin
                            active = 1'b0;
                            header_q.push_back(decoded_header(ST_OK, number_acc));
                        end else begin
                            cont_left = extra;
                            pos       = POS_CONT;
                        end
                    end
                end
                default: begin
                    // continuation marker bits are not checked
                    number_acc = {number_acc[NUMBER_W-7:0], b[5:0]};
                    if (cont_left != 0) cont_left = cont_left - 3'd1;
                    if (cont_left == 0) begin
                        active = 1'b0;
                        header_q.push_back(decoded_header(ST_OK, number_acc));
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            pos        = POS_SYNC0;
            active     = 1'b0;
            blk_bit    = 1'b0;
            size_rate  = '0;
            chan_bits  = '0;
            number_acc = '0;
            cont_left  = '0;
            header_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.status            = t_status'(i_status);
                got.variable_blocking = i_variable_blocking;
                got.block_samples     = i_block_samples;
                got.rate_hz           = i_rate_hz;
                got.channel_count     = i_channel_count;
                got.sample_bits       = i_sample_bits;
                got.coded_number      = i_coded_number;
                words++;
                if (header_q.size() == 0) begin
                    flag_fault($sformatf("result word with none expected: %s", show(got)));
                end else begin
                    want = header_q.pop_front();
                    if (got !== want)
                        flag_fault($sformatf("mismatch: expected %s, got %s",
                                             show(want), show(got)));
                end
            end
            if (i_in_valid && i_in_ready) parse_word(i_byte, i_start);
        end
        o_pending    <= header_q.size();
        o_fail_count <= faults;
        o_words      <= words;
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import ffhp_pkg::*;

    localparam int ITEM_TARGET = 1150;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [BYTE_W-1:0]   i_header_byte = '0;
    logic                i_frame_start = 1'b0;
    logic                i_ready = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [1:0]          o_status;
    logic                o_variable_blocking;
    logic [SAMP_W-1:0]   o_block_samples;
    logic [RATE_W-1:0]   o_rate_hz;
    logic [CHAN_W-1:0]   o_channel_count;
    logic [BITS_W-1:0]   o_sample_bits;
    logic [NUMBER_W-1:0] o_coded_number;

    int                  fail_count;
    int                  pending;
    int                  words;
    int                  items_sent = 0;
    int                  idle_cycles = 0;
    int                  send_calm = 0;
    logic [BYTE_W-1:0]   frame_q[$];

    always #5 i_clk = ~i_clk;

    flac_frame_header_parser_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_header_byte       (i_header_byte),
        .i_frame_start       (i_frame_start),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_variable_blocking (o_variable_blocking),
        .o_block_samples     (o_block_samples),
        .o_rate_hz           (o_rate_hz),
        .o_channel_count     (o_channel_count),
        .o_sample_bits       (o_sample_bits),
        .o_coded_number      (o_coded_number)
    );

    ffhp_header_monitor u_mon (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_valid),
        .i_in_ready          (o_ready),
        .i_byte              (i_header_byte),
        .i_start             (i_frame_start),
        .i_out_valid         (o_valid),
        .i_out_ready         (i_ready),
        .i_status            (o_status),
        .i_variable_blocking (o_variable_blocking),
        .i_block_samples     (o_block_samples),
        .i_rate_hz           (o_rate_hz),
        .i_channel_count     (o_channel_count),
        .i_sample_bits       (o_sample_bits),
        .i_coded_number      (o_coded_number),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_words             (words)
    );

    // random gaps, broken by runs with no gaps at all
    function automatic int next_gap(inout int calm);
        int gap;
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
        end
        return gap;
    endfunction

    function automatic logic [BYTE_W-1:0] lead_byte(input int extra);
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom);
        if (extra == 0) return r & 8'h7F;
        return ~(8'hFF >> (extra + 1)) | (r & (8'hFF >> (extra + 2)));
    endfunction

    task automatic push_word(input logic [BYTE_W-1:0] b, input logic s);
        int gap;
        gap = next_gap(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_header_byte <= b;
        i_frame_start <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic build_header(input int extra);
        logic [BYTE_W-1:0] cont;
        frame_q.delete();
        frame_q.push_back(SYNC0_BYTE);
        frame_q.push_back(SYNC1_CODE | BYTE_W'($urandom_range(0, 3)));
        frame_q.push_back(BYTE_W'($urandom));
        frame_q.push_back(BYTE_W'($urandom));
        frame_q.push_back(lead_byte(extra));
        repeat (extra) begin
            cont = BYTE_W'($urandom);
            if ($urandom_range(0, 7) != 0) cont = 8'h80 | (cont & 8'h3F);
            frame_q.push_back(cont);
        end
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame_q.size(); k++) push_word(frame_q[k], k == 0);
        items_sent += frame_q.size();
    endtask

    initial begin : stimulus
        int kind;
        int extra;
        int keep;
        logic [BYTE_W-1:0] r;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_word(8'h00, 1'b0);     // idle, ignored
        push_word(8'h00, 1'b1);     // bad first sync
        push_word(8'hFF, 1'b1);
        push_word(8'hF4, 1'b0);     // bad second sync
        push_word(8'hFF, 1'b1);
        push_word(8'hF9, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h7F, 1'b0);     // single-byte number
        push_word(8'hFF, 1'b1);
        push_word(8'hF8, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h80, 1'b0);     // invalid lead
        push_word(8'hFF, 1'b1);
        push_word(8'hFA, 1'b0);     // restart mid-header
        push_word(8'hFF, 1'b1);
        push_word(8'hFB, 1'b0);
        push_word(8'hC9, 1'b0);
        push_word(8'h2C, 1'b0);
        push_word(8'hFE, 1'b0);     // seven-byte number, all ones
        repeat (6) push_word(8'hBF, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            kind  = $urandom_range(0, 99);
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6)
                                                : $urandom_range(0, 2);
            build_header(extra);
            if (kind < 70) begin
                send_frame();
            end else if (kind < 78) begin
                frame_q.delete();
                frame_q.push_back(BYTE_W'($urandom_range(0, 254)));
                send_frame();
            end else if (kind < 85) begin
                while (frame_q.size() > 2) void'(frame_q.pop_back());
                r = BYTE_W'($urandom);
                if ((r & SYNC1_MASK) == SYNC1_CODE) r = r ^ 8'h04;
                frame_q[1] = r;
                send_frame();
            end else if (kind < 92) begin
                while (frame_q.size() > 4) void'(frame_q.pop_back());
                frame_q.push_back(($urandom_range(0, 4) == 0) ? 8'hFF
                                  : (8'h80 | BYTE_W'($urandom_range(0, 63))));
                send_frame();
            end else if (kind < 97) begin
                keep = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > keep) void'(frame_q.pop_back());
                send_frame();
            end else begin
                repeat ($urandom_range(1, 4)) push_word(BYTE_W'($urandom), 1'b0);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("tb_top: %0d random header bytes after the directed set, %0d result words",
                 items_sent, words);
        $display("tb_top: sync faults, bad lead bytes, restarts, 1 to 7 byte numbers, %0d faults",
                 fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin : sink
        int gap;
        int calm;
        int taken;
        calm  = 0;
        taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = next_gap(calm);
            // long hold-offs so the block fills and stalls its input
            if (taken == 5 || taken == 120) gap = LONG_HOLD;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
